FILE: sv/atmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package atmf_pkg;

  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned SUM_W      = 16;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned WARM_W     = 16;
  localparam int unsigned MASK_W     = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIV_STEPS  = SUM_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0]  SUM_COUNT_RESET  = 6'd52;
  localparam logic [CNT_W-1:0]  MIN_WINDOW       = 6'd3;
  localparam logic [WARM_W-1:0] TURN_ON_RESET    = 16'd1000;
  localparam logic [MASK_W-1:0] DELAY_MASK_RESET = 32'd384;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_SET_AVG = 2'd1,
    CMD_ON      = 2'd2,
    CMD_OFF     = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUM_COUNT     = 2'd0,
    CFG_TURN_ON_DELAY = 2'd1,
    CFG_DELAY_MASK    = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_CHECK,
    ST_DIV,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef struct packed {
    cmd_e                   cmd;
    logic [4:0]             channel;
    logic [SAMPLE_BITS-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [4:0]             out_channel;
    logic [SAMPLE_BITS-1:0] average;
    logic                   average_new;
    logic                   on_state;
    logic                   sensor_power;
  } out_item_t;

endpackage

`default_nettype wire

FILE: sv/atmf_state_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module atmf_state_mem #(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = 5,
  parameter int unsigned DATA_W = 8,
  parameter logic [DATA_W-1:0] RESET_VAL = '0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid_q;
  logic [DATA_W-1:0] rd_data_q;
  logic              rd_valid_q;

  // entries never written read as their reset value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : RESET_VAL;

endmodule

`default_nettype wire

FILE: sv/atmf_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module atmf_divider import atmf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SUM_W-1:0] dividend_i,
  input  wire logic [CNT_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [SUM_W-1:0] quotient_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] step_q;
  logic [CNT_W-1:0]     rem_q;
  logic [CNT_W-1:0]     rem_d;
  logic [CNT_W-1:0]     dsr_q;
  logic [SUM_W-1:0]     quo_q;
  logic [CNT_W:0]       trial;
  logic                 fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};
  assign rem_d = fits ? CNT_W'(trial - {1'b0, dsr_q}) : CNT_W'(trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[SUM_W-2:0], fits};
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

FILE: sv/adc_trimmed_mean_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// Multi-channel ADC averager with an olympic trimmed mean: each channel
// collects sum_count samples (at least three), drops the lowest and highest,
// and stores (sum - min - max) / (count - 2) as its average. Every request
// returns one result with the channel's average, on state and sensor power
// drive. Requests are handled one at a time; an item that completes a window
// also waits for the 16-step bit-serial divider. Per-channel state sits in a
// state memory with a read and a write port and per-entry valid bits, so it
// is ready right after reset with no clearing pass. A finished result waits
// in the output register while the next request is accepted. Configuration
// writes are taken in every cycle and must only be issued while the block is
// idle.
module adc_trimmed_mean_filter import atmf_pkg::*; #(
  parameter int unsigned NUM_CHANNELS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_item_t              in_req_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_item_t                  out_rsp_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AddrW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [SAMPLE_BITS:0] MinReset = {1'b1, {SAMPLE_BITS{1'b0}}};

  typedef struct packed {
    logic [SUM_W-1:0]       sum;
    logic [CNT_W-1:0]       cnt;
    logic [SAMPLE_BITS:0]   min;
    logic [SAMPLE_BITS-1:0] max;
    logic [SAMPLE_BITS-1:0] avg;
    logic                   en;
    logic [WARM_W-1:0]      warm;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);
  localparam entry_t EntryReset = '{
    sum:  '0,
    cnt:  '0,
    min:  MinReset,
    max:  '0,
    avg:  '0,
    en:   1'b1,
    warm: TURN_ON_RESET
  };

  state_e                 state_q, state_d;
  in_item_t               item_q;
  logic                   in_range_q;
  logic                   fresh_q;
  entry_t                 w_q;
  entry_t                 upd;
  entry_t                 rd_entry;
  logic [EntryW-1:0]      rd_data;
  out_item_t              out_q, out_d;
  logic                   out_valid_q;

  logic [CNT_W-1:0]       sum_count_q;
  logic [WARM_W-1:0]      turn_on_delay_q;
  logic [MASK_W-1:0]      delay_mask_q;
  logic [CNT_W-1:0]       eff;

  logic                   accept;
  logic                   req_in_range;
  logic                   mem_rd_en;
  logic                   mem_wr_en;
  logic                   div_start;
  logic                   div_done;
  logic [SUM_W-1:0]       quotient;
  logic                   out_load;
  logic                   complete;
  logic                   switched;
  logic [SAMPLE_BITS-1:0] smp;
  logic [AddrW-1:0]       addr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_count_q     <= SUM_COUNT_RESET;
      turn_on_delay_q <= TURN_ON_RESET;
      delay_mask_q    <= DELAY_MASK_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SUM_COUNT:     sum_count_q     <= CNT_W'(cfg_data_i);
        CFG_TURN_ON_DELAY: turn_on_delay_q <= WARM_W'(cfg_data_i);
        CFG_DELAY_MASK:    delay_mask_q    <= MASK_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign eff          = (sum_count_q < MIN_WINDOW) ? MIN_WINDOW : sum_count_q;
  assign accept       = in_valid_i && in_ready_o;
  assign req_in_range = 32'(in_req_i.channel) < NUM_CHANNELS;
  assign smp          = SAMPLE_BITS'(item_q.sample);
  assign addr         = AddrW'(item_q.channel);
  assign switched     = delay_mask_q[item_q.channel];
  assign rd_entry     = entry_t'(rd_data);
  assign complete     = (item_q.cmd == CMD_TICK) && (w_q.cnt >= eff);

  atmf_state_mem #(
    .DEPTH    (NUM_CHANNELS),
    .ADDR_W   (AddrW),
    .DATA_W   (EntryW),
    .RESET_VAL(EntryReset)
  ) u_state_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (mem_rd_en),
    .rd_addr_i(addr),
    .rd_data_o(rd_data),
    .wr_en_i  (mem_wr_en),
    .wr_addr_i(addr),
    .wr_data_i(w_q)
  );

  atmf_divider u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(SUM_W'(w_q.sum - SUM_W'(w_q.min) - SUM_W'(w_q.max))),
    .divisor_i (CNT_W'(w_q.cnt - CNT_W'(2))),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = req_in_range ? ST_READ : ST_DONE;
        end
      end
      ST_READ:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_CHECK;
      ST_CHECK:  state_d = complete ? ST_DIV : ST_WRITE;
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE:  state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    mem_rd_en  = 1'b0;
    mem_wr_en  = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_READ:  mem_rd_en  = 1'b1;
      ST_CHECK: div_start  = complete;
      ST_WRITE: mem_wr_en  = 1'b1;
      ST_DONE:  out_load   = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_comb begin
    upd = rd_entry;
    case (item_q.cmd)
      CMD_TICK: begin
        if (!rd_entry.en) begin
          if (switched) begin
            upd.warm = turn_on_delay_q;
          end
          upd.sum = '0;
          upd.cnt = '0;
          upd.min = MinReset;
          upd.max = '0;
        end else if (switched && rd_entry.warm != '0) begin
          upd.warm = rd_entry.warm - 1'b1;
        end else if (rd_entry.cnt < eff) begin
          upd.sum = rd_entry.sum + SUM_W'(smp);
          upd.cnt = rd_entry.cnt + 1'b1;
          if ({1'b0, smp} < rd_entry.min) begin
            upd.min = {1'b0, smp};
          end
          if (smp > rd_entry.max) begin
            upd.max = smp;
          end
        end
      end
      CMD_SET_AVG: upd.avg = smp;
      CMD_ON:      upd.en  = 1'b1;
      CMD_OFF:     upd.en  = 1'b0;
      default: ;
    endcase
  end

  always_comb begin
    out_d             = '0;
    out_d.out_channel = item_q.channel;
    if (in_range_q) begin
      out_d.average      = w_q.avg;
      out_d.average_new  = fresh_q;
      out_d.on_state     = w_q.en;
      out_d.sensor_power = switched && w_q.en;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      fresh_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        fresh_q <= 1'b0;
      end else if (state_q == ST_DIV && div_done) begin
        fresh_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q     <= in_req_i;
      in_range_q <= req_in_range;
    end
    if (state_q == ST_UPDATE) begin
      w_q <= upd;
    end else if (state_q == ST_DIV && div_done) begin
      w_q.avg <= SAMPLE_BITS'(quotient);
      w_q.sum <= '0;
      w_q.cnt <= '0;
      w_q.min <= MinReset;
      w_q.max <= '0;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_div_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_write_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr_en |-> in_range_q)
    else $error("state write for a channel out of range");

  a_new_avg_on : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.average_new |-> out_rsp_o.on_state)
    else $error("new average reported on a disabled channel");

  a_accept_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ST_IDLE)
    else $error("request accepted but sequencer stayed idle");

endmodule

`default_nettype wire

FILE: tb/tb_adc_trimmed_mean_filter.sv
`timescale 1ns / 1ps

module tb_adc_trimmed_mean_filter;
  import atmf_pkg::*;

  localparam int NUM_CH      = 32;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 30;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 128;
  localparam int DIR_ROWS    = 30;

  typedef enum logic [1:0] {
    ROW_PRED,
    ROW_TYPED,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    cmd_e        cmd;
    cfg_idx_e    idx;
    logic [4:0]  ch;
    logic [31:0] val;
    out_item_t   rsp;
  } dir_row_t;

  // directed rows; typed results are taken as they stand, the rest come from the predictor
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{ROW_TYPED, CMD_SET_AVG, CFG_SUM_COUNT, 5'd0, 32'd1023, '{5'd0, 10'd1023, 1'b0, 1'b1, 1'b0}},
    '{ROW_TYPED, CMD_TICK, CFG_SUM_COUNT, 5'd5, 32'd1023, '{5'd5, 10'd0, 1'b0, 1'b1, 1'b0}},
    '{ROW_PRED, CMD_TICK, CFG_SUM_COUNT, 5'd6, 32'd1023, '0},
    '{ROW_PRED, CMD_TICK, CFG_SUM_COUNT, 5'd6, 32'd1023, '0},
    '{ROW_PRED, CMD_TICK, CFG_SUM_COUNT, 5'd6, 32'd1, '0},
    '{ROW_TYPED, CMD_OFF, CFG_SUM_COUNT, 5'd7, 32'd0, '{5'd7, 10'd0, 1'b0, 1'b0, 1'b0}},
    '{ROW_TYPED, CMD_TICK, CFG_SUM_COUNT, 5'd7, 32'd512, '{5'd7, 10'd0, 1'b0, 1'b0, 1'b0}},
    '{ROW_TYPED, CMD_ON, CFG_SUM_COUNT, 5'd7, 32'd0, '{5'd7, 10'd0, 1'b0, 1'b1, 1'b1}},
    '{ROW_TYPED, CMD_TICK, CFG_SUM_COUNT, 5'd8, 32'd3, '{5'd8, 10'd0, 1'b0, 1'b1, 1'b1}},
    '{ROW_TYPED, CMD_SET_AVG, CFG_SUM_COUNT, 5'd8, 32'd682, '{5'd8, 10'd682, 1'b0, 1'b1, 1'b1}},
    '{ROW_TYPED, CMD_OFF, CFG_SUM_COUNT, 5'd2, 32'd0, '{5'd2, 10'd0, 1'b0, 1'b0, 1'b0}},
    '{ROW_TYPED, CMD_TICK, CFG_SUM_COUNT, 5'd2, 32'd999, '{5'd2, 10'd0, 1'b0, 1'b0, 1'b0}},
    '{ROW_TYPED, CMD_ON, CFG_SUM_COUNT, 5'd2, 32'd0, '{5'd2, 10'd0, 1'b0, 1'b1, 1'b0}},
    '{ROW_TYPED, CMD_OFF, CFG_SUM_COUNT, 5'd31, 32'd0, '{5'd31, 10'd0, 1'b0, 1'b0, 1'b0}},
    '{ROW_TYPED, CMD_SET_AVG, CFG_SUM_COUNT, 5'd31, 32'd77, '{5'd31, 10'd77, 1'b0, 1'b0, 1'b0}},
    '{ROW_TYPED, CMD_ON, CFG_SUM_COUNT, 5'd31, 32'd0, '{5'd31, 10'd77, 1'b0, 1'b1, 1'b0}},
    // window length below three acts as three; open window on ch6 closes at once
    '{ROW_CFG, CMD_TICK, CFG_SUM_COUNT, 5'd0, 32'd0, '0},
    '{ROW_PRED, CMD_TICK, CFG_SUM_COUNT, 5'd6, 32'd0, '0},
    '{ROW_PRED, CMD_TICK, CFG_SUM_COUNT, 5'd4, 32'd1023, '0},
    '{ROW_PRED, CMD_TICK, CFG_SUM_COUNT, 5'd4, 32'd0, '0},
    '{ROW_TYPED, CMD_TICK, CFG_SUM_COUNT, 5'd4, 32'd500, '{5'd4, 10'd500, 1'b1, 1'b1, 1'b0}},
    // warm-up reload on an off tick, then a full window
    '{ROW_CFG, CMD_TICK, CFG_TURN_ON_DELAY, 5'd0, 32'd1, '0},
    '{ROW_CFG, CMD_TICK, CFG_DELAY_MASK, 5'd0, 32'hFFFF_FFFF, '0},
    '{ROW_TYPED, CMD_OFF, CFG_SUM_COUNT, 5'd9, 32'd0, '{5'd9, 10'd0, 1'b0, 1'b0, 1'b0}},
    '{ROW_PRED, CMD_TICK, CFG_SUM_COUNT, 5'd9, 32'd300, '0},
    '{ROW_TYPED, CMD_ON, CFG_SUM_COUNT, 5'd9, 32'd0, '{5'd9, 10'd0, 1'b0, 1'b1, 1'b1}},
    '{ROW_TYPED, CMD_TICK, CFG_SUM_COUNT, 5'd9, 32'd1023, '{5'd9, 10'd0, 1'b0, 1'b1, 1'b1}},
    '{ROW_PRED, CMD_TICK, CFG_SUM_COUNT, 5'd9, 32'd10, '0},
    '{ROW_PRED, CMD_TICK, CFG_SUM_COUNT, 5'd9, 32'd20, '0},
    '{ROW_PRED, CMD_TICK, CFG_SUM_COUNT, 5'd9, 32'd900, '0}
  };

  localparam logic [5:0]  PHASE_WIN [PHASES] = '{6'd63, 6'd3, 6'd0, 6'd7, 6'd1, 6'd12, 6'd2,
                                                 6'd52};
  localparam logic [15:0] PHASE_WARM [PHASES] = '{16'd0, 16'd65535, 16'd3, 16'd1, 16'd0,
                                                  16'd4, 16'd2, 16'd9};
  localparam logic [31:0] PHASE_MASK [PHASES] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hAAAA_AAAA,
                                                  32'h5555_5555, 32'hFFFF_FFFF, 32'h0F0F_0F0F,
                                                  32'hF0F0_F0F0, 32'h0000_0180};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_req_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_rsp_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // predictor state
  logic [5:0]  win_len_cfg;
  logic [15:0] warm_ticks_cfg;
  logic [31:0] switched_cfg;
  logic [15:0] win_sum [NUM_CH];
  logic [5:0]  win_count [NUM_CH];
  logic [10:0] win_min [NUM_CH];
  logic [9:0]  win_max [NUM_CH];
  logic [9:0]  avg_mem [NUM_CH];
  logic        chan_on [NUM_CH];
  logic [15:0] warm_left [NUM_CH];

  out_item_t awaited_reports [$];
  int        report_errors;
  int        quiet_cycles;
  int        send_idle_pct;
  int        recv_stall_pct;

  adc_trimmed_mean_filter DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void clear_window(logic [4:0] c);
    win_sum[c]   = '0;
    win_count[c] = '0;
    win_min[c]   = 11'd1024;
    win_max[c]   = '0;
  endfunction

  function automatic out_item_t channel_report(in_item_t req);
    out_item_t   rsp;
    logic [4:0]  c;
    logic [5:0]  eff;
    logic [15:0] diff;
    logic        switched;
    c        = req.channel;
    eff      = (win_len_cfg < MIN_WINDOW) ? MIN_WINDOW : win_len_cfg;
    switched = switched_cfg[c];
    rsp      = '0;
    rsp.out_channel = c;
    case (req.cmd)
      CMD_TICK: begin
        if (!chan_on[c]) begin
          if (switched) warm_left[c] = warm_ticks_cfg;
          clear_window(c);
        end else begin
          if (switched && warm_left[c] != 16'd0) begin
            warm_left[c] = warm_left[c] - 16'd1;
          end else if (win_count[c] < eff) begin
            win_sum[c]   = win_sum[c] + 16'(req.sample);
            win_count[c] = win_count[c] + 6'd1;
            if ({1'b0, req.sample} < win_min[c]) win_min[c] = {1'b0, req.sample};
            if (req.sample > win_max[c]) win_max[c] = req.sample;
          end
          if (win_count[c] >= eff) begin
            diff = win_sum[c] - 16'(win_min[c]) - 16'(win_max[c]);
            avg_mem[c] = 10'(diff / 16'(win_count[c] - 6'd2));
            clear_window(c);
            rsp.average_new = 1'b1;
          end
        end
      end
      CMD_SET_AVG: avg_mem[c] = req.sample;
      CMD_ON:      chan_on[c] = 1'b1;
      default:     chan_on[c] = 1'b0;
    endcase
    rsp.average      = avg_mem[c];
    rsp.on_state     = chan_on[c];
    rsp.sensor_power = switched & chan_on[c];
    return rsp;
  endfunction

  task automatic check_field(string field, logic [9:0] want, logic [9:0] got, logic [4:0] ch);
    if (got !== want) begin
      report_errors++;
      if (report_errors <= 10)
        $display("ch %0d %s: expected %0d, got %0d", ch, field, want, got);
    end
  endtask

  // call right after a rising edge
  task automatic send_request(in_item_t req, logic typed, out_item_t typed_rsp);
    out_item_t want;
    cfg_valid_i <= 1'b0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    want = channel_report(req);
    awaited_reports.push_back(typed ? typed_rsp : want);
  endtask

  // only while idle: drain outstanding results first
  task automatic write_register(cfg_idx_e idx, logic [31:0] data);
    in_valid_i <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SUM_COUNT:     win_len_cfg = data[5:0];
      CFG_TURN_ON_DELAY: warm_ticks_cfg = data[15:0];
      default:           switched_cfg = data;
    endcase
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_reports.size() == 0) begin
        report_errors++;
        if (report_errors <= 10)
          $display("unexpected result on ch %0d", out_rsp_o.out_channel);
      end else begin
        want = awaited_reports.pop_front();
        check_field("out_channel", 10'(want.out_channel), 10'(out_rsp_o.out_channel),
                    want.out_channel);
        check_field("average", want.average, out_rsp_o.average, want.out_channel);
        check_field("average_new", 10'(want.average_new), 10'(out_rsp_o.average_new),
                    want.out_channel);
        check_field("on_state", 10'(want.on_state), 10'(out_rsp_o.on_state),
                    want.out_channel);
        check_field("sensor_power", 10'(want.sensor_power), 10'(out_rsp_o.sensor_power),
                    want.out_channel);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_item_t   req;
    logic [4:0] hot [3];
    int         hot_n;
    int         pick;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_req_i       = '0;
    out_ready_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    report_errors  = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    win_len_cfg    = SUM_COUNT_RESET;
    warm_ticks_cfg = TURN_ON_RESET;
    switched_cfg   = DELAY_MASK_RESET;
    for (int c = 0; c < NUM_CH; c++) begin
      clear_window(c[4:0]);
      avg_mem[c]   = '0;
      chan_on[c]   = 1'b1;
      warm_left[c] = TURN_ON_RESET;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TABLE[i].kind == ROW_CFG) begin
        write_register(DIR_TABLE[i].idx, DIR_TABLE[i].val);
      end else begin
        req.cmd     = DIR_TABLE[i].cmd;
        req.channel = DIR_TABLE[i].ch;
        req.sample  = DIR_TABLE[i].val[9:0];
        send_request(req, DIR_TABLE[i].kind == ROW_TYPED, DIR_TABLE[i].rsp);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      write_register(CFG_SUM_COUNT, {26'd0, PHASE_WIN[p]});
      write_register(CFG_TURN_ON_DELAY, {16'd0, PHASE_WARM[p]});
      write_register(CFG_DELAY_MASK, PHASE_MASK[p]);
      send_idle_pct  = (p % 4 == 1) ? 59 : (p % 4 == 3) ? 12 : 0;
      recv_stall_pct = (p % 4 == 2) ? 59 : (p % 4 == 3) ? 12 : 0;
      hot_n = (PHASE_WIN[p] > 6'd20) ? 1 : 3;
      for (int h = 0; h < hot_n; h++) begin
        hot[h] = 5'($urandom_range(0, NUM_CH - 1));
        // off, off tick (warm-up reload on switched channels), on
        req.channel = hot[h];
        req.sample  = 10'($urandom_range(0, 1023));
        req.cmd     = CMD_OFF;
        send_request(req, 1'b0, '0);
        req.cmd     = CMD_TICK;
        send_request(req, 1'b0, '0);
        req.cmd     = CMD_ON;
        send_request(req, 1'b0, '0);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 82)      req.cmd = CMD_TICK;
        else if (pick < 89) req.cmd = CMD_SET_AVG;
        else if (pick < 95) req.cmd = CMD_ON;
        else                req.cmd = CMD_OFF;
        if ($urandom_range(0, 99) < 85)
          req.channel = hot[$urandom_range(0, hot_n - 1)];
        else
          req.channel = 5'($urandom_range(0, NUM_CH - 1));
        pick = $urandom_range(0, 99);
        if (pick < 8)       req.sample = 10'd0;
        else if (pick < 16) req.sample = 10'd1023;
        else                req.sample = 10'($urandom_range(0, 1023));
        send_request(req, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (report_errors == 0 && awaited_reports.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
sv/atmf_pkg.sv
sv/atmf_state_mem.sv
sv/atmf_divider.sv
sv/adc_trimmed_mean_filter.sv
tb/tb_adc_trimmed_mean_filter.sv
